@@ rtl/core/nmcs_pkg.sv @@
`timescale 1ns / 1ps

package nmcs_pkg;

	// Width of every period register
	localparam int PERIOD_BITS = 24;
	localparam int CFG_DATA_BITS = 24;
	localparam int CFG_INDEX_BITS = 3;

	// Register indexes on the configuration port
	localparam logic [CFG_INDEX_BITS-1:0] REG_DISPLAY_ENABLE = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TEMP_INTEGER   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TEMP_DECIMAL   = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SCAN_PERIOD    = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SECOND_PERIOD  = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ANIM_PERIOD    = 3'd5;

	// Reset values of the period registers
	localparam logic [PERIOD_BITS-1:0] SCAN_PERIOD_RST   = 24'd2000;
	localparam logic [PERIOD_BITS-1:0] SECOND_PERIOD_RST = 24'd1000000;
	localparam logic [PERIOD_BITS-1:0] ANIM_PERIOD_RST   = 24'd100000;

	// Item function and display modes
	localparam logic FUNC_TICK    = 1'b0;
	localparam logic FUNC_SETTIME = 1'b1;

	typedef enum logic [1:0] {
		MODE_TIME   = 2'd0,
		MODE_TEMP   = 2'd1,
		MODE_MANUAL = 2'd2,
		MODE_ANIM   = 2'd3
	} mode_t;

	// Cathode codes
	localparam logic [3:0] CODE_BLANK = 4'd14;
	localparam logic [3:0] CODE_OFF   = 4'd15;

	// Clock limits
	localparam logic [6:0] MAX_SEC_MIN = 7'd59;

	// v / 10 by reciprocal multiply; the 4-bit result is exact for v below 160
	function automatic logic [3:0] bcd_tens(input logic [7:0] v);
		logic [15:0] prod;
		prod = {8'd0, v} * 16'd205;
		return prod[14:11];
	endfunction

	function automatic logic [3:0] bcd_units(input logic [7:0] v);
		logic [15:0] prod;
		logic [4:0]  quo;
		logic [7:0]  tenx;
		prod = {8'd0, v} * 16'd205;
		quo  = prod[15:11];
		// 10 * quo as 8 * quo + 2 * quo
		tenx = {quo[4:0], 3'b000} + {2'b00, quo, 1'b0};
		return 4'(v - tenx);
	endfunction

endpackage

@@ rtl/core/nmcs_timer.sv @@
`timescale 1ns / 1ps

// Saturating tick timer: fires on the tick that brings the count to period.
module nmcs_timer
	import nmcs_pkg::*;
#(
	parameter int COUNTER_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   tick,
	input  logic                   clear,
	input  logic [PERIOD_BITS-1:0] period,
	output logic                   fire
);

	localparam int CmpBits = (COUNTER_BITS > PERIOD_BITS) ? COUNTER_BITS : PERIOD_BITS;

	logic [COUNTER_BITS-1:0] elapsed_q;
	logic [COUNTER_BITS-1:0] count_inc;

	assign count_inc = (&elapsed_q) ? elapsed_q
		: elapsed_q + {{(COUNTER_BITS-1){1'b0}}, 1'b1};
	assign fire = tick && (CmpBits'(count_inc) >= CmpBits'(period));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
		end else if (clear || fire) begin
			elapsed_q <= '0;
		end else if (tick) begin
			elapsed_q <= count_inc;
		end
	end

endmodule

@@ rtl/core/nixie_multiplex_clock_scanner.sv @@
`timescale 1ns / 1ps

// Four-tube multiplexed clock display scanner.
// Input channel (in_valid / in_stall): one transaction is either a time-base
// tick (func = 0) or a set-time load (func = 1), plus the display mode and the
// manual digit codes. Output channel (out_valid / out_stall): one transaction
// per input transaction, carrying anode select, cathode code, dots, the hour
// rollover flag and the current hour, minute and second.
// A transaction lands in the input register and then updates the display/clock
// state, which doubles as the result register. Throughput is one transaction
// per cycle while the receiver does not stall; all per-item work is one
// short combinational pass (timer compare, clock increment, divide-by-ten).
// If the receiver stalls, the result holds and the input register holds, so
// in_stall rises only when both are full; one extra transaction is absorbed.
// Reset (arst_n low, asynchronous) clears the clock, timers, dots and anodes,
// sets the animation direction to lighting, blanks the display enable and
// loads the default periods. The user must write configuration via cfg_we /
// cfg_index / cfg_data only while no transaction is in flight (not enforced).
module nixie_multiplex_clock_scanner
	import nmcs_pkg::*;
#(
	parameter int COUNTER_BITS = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write port
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	// input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      func,
	input  logic [1:0]                mode,
	input  logic [4:0]                set_hour,
	input  logic [5:0]                set_minute,
	input  logic [5:0]                set_second,
	input  logic [15:0]               manual_digits,
	// output channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [3:0]                tube_select,
	output logic [3:0]                digit_code,
	output logic [3:0]                dot_lines,
	output logic                      hour_done,
	output logic [4:0]                cur_hour,
	output logic [5:0]                cur_minute,
	output logic [5:0]                cur_second
);

	// Configuration registers
	logic                   display_enable_q;
	logic [7:0]             temp_integer_q;
	logic [6:0]             temp_decimal_q;
	logic [PERIOD_BITS-1:0] scan_period_q;
	logic [PERIOD_BITS-1:0] second_period_q;
	logic [PERIOD_BITS-1:0] anim_period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_enable_q <= 1'b0;
			temp_integer_q   <= '0;
			temp_decimal_q   <= '0;
			scan_period_q    <= SCAN_PERIOD_RST;
			second_period_q  <= SECOND_PERIOD_RST;
			anim_period_q    <= ANIM_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DISPLAY_ENABLE: display_enable_q <= cfg_data[0];
				REG_TEMP_INTEGER:   temp_integer_q   <= cfg_data[7:0];
				REG_TEMP_DECIMAL:   temp_decimal_q   <= cfg_data[6:0];
				REG_SCAN_PERIOD:    scan_period_q    <= cfg_data[PERIOD_BITS-1:0];
				REG_SECOND_PERIOD:  second_period_q  <= cfg_data[PERIOD_BITS-1:0];
				REG_ANIM_PERIOD:    anim_period_q    <= cfg_data[PERIOD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Input register stage
	// ---------------------------------------------------------------
	logic        valid_s1;
	logic        func_s1;
	mode_t       mode_s1;
	logic [4:0]  set_hour_s1;
	logic [5:0]  set_minute_s1;
	logic [5:0]  set_second_s1;
	logic [15:0] manual_s1;

	logic out_valid_q;
	logic advance;

	// s1 moves into the result register whenever that register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1       <= func;
			mode_s1       <= mode_t'(mode);
			set_hour_s1   <= set_hour;
			set_minute_s1 <= set_minute;
			set_second_s1 <= set_second;
			manual_s1     <= manual_digits;
		end
	end

	// ---------------------------------------------------------------
	// Timers
	// ---------------------------------------------------------------
	logic tick;
	logic second_fire;
	logic anim_fire;
	logic scan_fire;

	assign tick = advance && (func_s1 == FUNC_TICK);

	nmcs_timer #(.COUNTER_BITS(COUNTER_BITS)) u_second_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick && (mode_s1 == MODE_TIME)),
		.clear  (advance && (func_s1 == FUNC_SETTIME)),
		.period (second_period_q),
		.fire   (second_fire)
	);

	nmcs_timer #(.COUNTER_BITS(COUNTER_BITS)) u_anim_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick && (mode_s1 == MODE_ANIM)),
		.clear  (1'b0),
		.period (anim_period_q),
		.fire   (anim_fire)
	);

	nmcs_timer #(.COUNTER_BITS(COUNTER_BITS)) u_scan_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.clear  (1'b0),
		.period (scan_period_q),
		.fire   (scan_fire)
	);

	// ---------------------------------------------------------------
	// Display and clock state (also the result register)
	// ---------------------------------------------------------------
	logic [1:0] scan_pos_q;
	logic [4:0] hour_q;
	logic [5:0] minute_q;
	logic [5:0] second_q;
	logic [3:0] dot_q;
	logic [1:0] anim_pos_q;
	logic       anim_dir_q;
	logic [3:0] anode_q;
	logic [3:0] digit_q;
	logic       hour_done_q;

	// Next-state values for a tick transaction
	logic [6:0] sec_inc;
	logic [6:0] min_inc;
	logic [5:0] second_d;
	logic [5:0] minute_d;
	logic       hour_flag_d;
	logic [3:0] dot_d;
	logic [7:0] temp_mag;
	logic [7:0] val_a;
	logic [7:0] val_b;
	logic [3:0] tube_code;

	assign temp_mag = temp_integer_q[7] ? (~temp_integer_q + 8'd1) : temp_integer_q;

	always_comb begin
		// seconds/minutes run 7 bits wide so a loaded 63 still rolls over
		sec_inc     = {1'b0, second_q} + 7'd1;
		min_inc     = {1'b0, minute_q};
		second_d    = second_q;
		minute_d    = minute_q;
		hour_flag_d = 1'b0;
		dot_d       = dot_q;

		case (mode_s1)
			MODE_TIME: begin
				if (second_fire) begin
					dot_d[1] = ~dot_q[1];
					if (sec_inc > MAX_SEC_MIN) begin
						second_d = '0;
						min_inc  = {1'b0, minute_q} + 7'd1;
					end else begin
						second_d = sec_inc[5:0];
					end
					if (min_inc > MAX_SEC_MIN) begin
						minute_d    = '0;
						hour_flag_d = 1'b1;
					end else begin
						minute_d = min_inc[5:0];
					end
				end
			end
			MODE_TEMP: begin
				dot_d[1] = 1'b1;
				dot_d[0] = temp_integer_q[7];
			end
			MODE_ANIM: begin
				if (anim_fire) begin
					dot_d[anim_pos_q] = anim_dir_q;
				end
			end
			default: ;
		endcase

		// Digit for the tube the scan steps onto, from the updated clock in time mode
		if (mode_s1 == MODE_TIME) begin
			val_a = {3'b000, hour_q};
			val_b = {2'b00, minute_d};
		end else begin
			val_a = temp_mag;
			val_b = {1'b0, temp_decimal_q};
		end

		case (mode_s1)
			MODE_MANUAL: tube_code = manual_s1[{scan_pos_q, 2'b00} +: 4];
			MODE_ANIM:   tube_code = CODE_BLANK;
			default: begin
				case (scan_pos_q)
					2'd0:    tube_code = bcd_tens(val_a);
					2'd1:    tube_code = bcd_units(val_a);
					2'd2:    tube_code = bcd_tens(val_b);
					default: tube_code = bcd_units(val_b);
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_pos_q  <= '0;
			hour_q      <= '0;
			minute_q    <= '0;
			second_q    <= '0;
			dot_q       <= '0;
			anim_pos_q  <= '0;
			anim_dir_q  <= 1'b1;
			anode_q     <= '0;
			digit_q     <= '0;
			hour_done_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (advance) begin
				if (func_s1 == FUNC_SETTIME) begin
					hour_q      <= set_hour_s1;
					minute_q    <= set_minute_s1;
					second_q    <= set_second_s1;
					hour_done_q <= 1'b0;
				end else begin
					minute_q    <= minute_d;
					second_q    <= second_d;
					hour_done_q <= hour_flag_d;
					dot_q       <= dot_d;
					if (anim_fire) begin
						if (&anim_pos_q) begin
							anim_dir_q <= ~anim_dir_q;
						end
						anim_pos_q <= anim_pos_q + 2'd1;
					end
					if (scan_fire) begin
						anode_q    <= 4'b0001 << scan_pos_q;
						digit_q    <= display_enable_q ? tube_code : CODE_OFF;
						scan_pos_q <= scan_pos_q + 2'd1;
					end
				end
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign tube_select = anode_q;
	assign digit_code  = digit_q;
	assign dot_lines   = dot_q;
	assign hour_done   = hour_done_q;
	assign cur_hour    = hour_q;
	assign cur_minute  = minute_q;
	assign cur_second  = second_q;

endmodule

@@ rtl/core/nmcs_checker.sv @@
`timescale 1ns / 1ps

module nmcs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [3:0] tube_select,
	input logic [3:0] digit_code,
	input logic       hour_done,
	input logic [5:0] cur_minute
);

	// At most one anode is ever driven
	a_one_anode: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tube_select))
		else $error("more than one anode enabled");

	// An hour rollover always leaves the minutes at zero
	a_rollover_min: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hour_done) |-> (cur_minute == 6'd0))
		else $error("hour_done with nonzero minutes");

	// A stalled result keeps its anode select and cathode code
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable(tube_select) && $stable(digit_code)))
		else $error("stalled result changed");

endmodule

bind nixie_multiplex_clock_scanner nmcs_checker u_nmcs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.tube_select (tube_select),
	.digit_code  (digit_code),
	.hour_done   (hour_done),
	.cur_minute  (cur_minute)
);
